// ===== rtl/b64d_pkg.sv =====
// shared types, constants and the character decode function of the base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

	// depth of the job queue between the front and back parts
	localparam int JOB_QUEUE_DEPTH = 2;

	// special characters
	localparam logic [7:0] PAD_CHAR       = 8'h3D; // '='
	localparam logic [7:0] PLUS_CHAR      = 8'h2B; // '+'
	localparam logic [7:0] SLASH_CHAR     = 8'h2F; // '/'
	localparam logic [7:0] MINUS_CHAR     = 8'h2D; // '-'
	localparam logic [7:0] UNDERLINE_CHAR = 8'h5F; // '_'

	// quartet positions
	localparam logic [1:0] POS0 = 2'd0;
	localparam logic [1:0] POS1 = 2'd1;
	localparam logic [1:0] POS2 = 2'd2;
	localparam logic [1:0] POS3 = 2'd3;

	// one character with its end flag
	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_message;
	} in_item_t;

	// one result
	typedef struct packed {
		logic [7:0] data_byte;
		logic       bad_input;
		logic       final_result;
	} out_item_t;

	// work handed from front to back: one to three bytes, already compacted
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [1:0] count;   // number of bytes, 1 to 3
		logic       bad;     // error result
		logic       fin;     // last byte ends the message
	} job_t;

	// bit 6 set: not in either alphabet; else bits 5:0 hold the sextet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == PLUS_CHAR || c == MINUS_CHAR) begin
			r = 7'd62;
		end else if (c == SLASH_CHAR || c == UNDERLINE_CHAR) begin
			r = 7'd63;
		end
		return r;
	endfunction

endpackage

// ===== rtl/base64url_decoder.sv =====
// top level of the streaming base64 / base64url decoder
//
//   channel  | handshake         | payload             | transfer when
//   ---------+-------------------+---------------------+-------------------
//   input    | push / full       | item   (in_item_t)  | push && !full
//   result   | empty / pop       | result (out_item_t) | pop && !empty
//
// one character is taken per cycle while the job queue has room; the front
// part decides the quartet in the cycle of the transfer
// results leave one per cycle from the back part while results are popped, so a
// full quartet of three bytes gives three results in turn; the queue absorbs the wait
// a job passes a queue slot, the back job register and the output register
// reset clears quartet state, queue pointers and the output valid flag
// a stalled result side fills the queue and then raises full
`timescale 1ns / 1ps

module base64url_decoder import b64d_pkg::*; #(
	parameter int QueueDepth = JOB_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	// front to queue
	logic accept;
	logic job_valid;
	job_t job;

	// queue to back
	logic job_avail;
	logic job_take;
	job_t job_head;

	// a character is taken whenever the queue can hold a job
	assign accept = push && !full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job_valid (job_valid),
		.job       (job)
	);

	// decouples character intake from byte output
	b64d_job_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_valid),
		.wr_data   (job),
		.rd_en     (job_take),
		.rd_data   (job_head),
		.not_empty (job_avail),
		.full      (full)
	);

	// one byte per cycle into the output register while it is empty or being popped
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job_in    (job_head),
		.job_take  (job_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// ===== rtl/b64d_front.sv =====
// front part: takes characters, tracks the quartet and forms byte jobs
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     job_valid,
	output job_t     job
);

	logic [1:0]  pos_q, pos_d;
	logic [17:0] store_q, store_d;
	logic        third_pad_q, third_pad_d;
	logic        discard_q, discard_d;

	logic [6:0]  sx;
	logic        sym_ok;
	logic        pad;
	logic        eom;
	logic [5:0]  sext;
	logic [17:0] shifted;

	// compact the bytes of a 24 bit block, dropping padded positions
	function automatic job_t build_job(input logic [23:0] block, input logic pad2,
			input logic pad3, input logic fin);
		job_t j;
		j.byte0 = block[23:16];
		j.byte1 = pad2 ? block[7:0] : block[15:8];
		j.byte2 = block[7:0];
		j.count = 2'd1 + {1'b0, ~pad2} + {1'b0, ~pad3};
		j.bad   = 1'b0;
		j.fin   = fin;
		return j;
	endfunction

	assign sx      = sextet_of(item.symbol);
	assign sym_ok  = ~sx[6];
	assign pad     = (item.symbol == PAD_CHAR);
	assign eom     = item.end_of_message;
	assign sext    = pad ? 6'd0 : sx[5:0];
	assign shifted = {store_q[11:0], sext};

	always_comb begin
		pos_d       = pos_q;
		store_d     = store_q;
		third_pad_d = third_pad_q;
		discard_d   = discard_q;
		job_valid   = 1'b0;
		job         = '{byte0: 8'd0, byte1: 8'd0, byte2: 8'd0, count: 2'd1,
			bad: 1'b0, fin: 1'b0};
		if (accept) begin
			if (discard_q) begin
				if (eom) begin
					discard_d   = 1'b0;
					pos_d       = POS0;
					store_d     = '0;
					third_pad_d = 1'b0;
				end
			end else if ((!pos_q[1] && (!sym_ok || (eom && pos_q == POS0)))
					|| (pos_q[1] && !pad && !sym_ok)) begin
				// bad character, or a lone last character
				job_valid   = 1'b1;
				job.bad     = 1'b1;
				job.fin     = 1'b1;
				pos_d       = POS0;
				store_d     = '0;
				third_pad_d = 1'b0;
				discard_d   = ~eom;
			end else begin
				case (pos_q)
					POS0, POS1: begin
						if (eom) begin
							job_valid   = 1'b1;
							job         = build_job({shifted[11:0], 12'd0}, 1'b1, 1'b1, 1'b1);
							pos_d       = POS0;
							store_d     = '0;
							third_pad_d = 1'b0;
						end else begin
							store_d = shifted;
							pos_d   = pos_q + 2'd1;
						end
					end
					POS2: begin
						if (eom) begin
							job_valid   = 1'b1;
							job         = build_job({shifted, 6'd0}, pad, 1'b1, 1'b1);
							pos_d       = POS0;
							store_d     = '0;
							third_pad_d = 1'b0;
						end else begin
							store_d     = shifted;
							third_pad_d = pad;
							pos_d       = POS3;
						end
					end
					default: begin
						job_valid   = 1'b1;
						job         = build_job({store_q, sext}, third_pad_q, pad, eom);
						pos_d       = POS0;
						store_d     = '0;
						third_pad_d = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS0;
			store_q     <= '0;
			third_pad_q <= 1'b0;
			discard_q   <= 1'b0;
		end else begin
			pos_q       <= pos_d;
			store_q     <= store_d;
			third_pad_q <= third_pad_d;
			discard_q   <= discard_d;
		end
	end

endmodule

// ===== rtl/b64d_job_queue.sv =====
// short register queue of byte jobs between front and back
`timescale 1ns / 1ps

module b64d_job_queue import b64d_pkg::*; #(
	parameter int DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic not_empty,
	output logic full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/b64d_back.sv =====
// back part: unpacks jobs into single results behind an output register
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_avail,
	input  job_t      job_in,
	output logic      job_take,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	job_t       job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	out_item_t  out_q;
	logic       out_valid_q;

	logic       adv;
	logic       last;
	logic [7:0] sel_byte;

	assign last     = (idx_q == job_q.count - 2'd1);
	assign adv      = job_valid_q && (!out_valid_q || pop);
	assign job_take = job_avail && (!job_valid_q || (adv && last));
	assign empty    = ~out_valid_q;
	assign result   = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = job_q.byte0;
			2'd1:    sel_byte = job_q.byte1;
			default: sel_byte = job_q.byte2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job_in;
		end
		if (adv) begin
			out_q.data_byte    <= job_q.bad ? 8'd0 : sel_byte;
			out_q.bad_input    <= job_q.bad;
			out_q.final_result <= job_q.fin && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				job_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (adv) begin
				if (last) begin
					job_valid_q <= 1'b0;
					idx_q       <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/b64d_checker.sv =====
// port level checks of the decoder, bound to the top level
`timescale 1ns / 1ps

module b64d_checker import b64d_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// a waiting result stays until it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before transfer");

	// a waiting result does not change before it is taken
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("result changed while stalled");

	// the result side only drains through a transfer
	a_empty_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result side emptied without a pop");

	// the input side only fills up after an input transfer
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("input side filled without a push");

	// an error result carries a zero byte and ends the message
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.bad_input) |-> (result.final_result && result.data_byte == 8'd0))
		else $error("malformed error result");

endmodule

bind base64url_decoder b64d_checker u_checker (.*);
